[rtl/swarq_pkg.sv]
// swarq_pkg: sizes, codes, types and index helpers for the sliding-window arq sender
// no dependencies; imported by the interfaces, the wait fifo and the top level
package swarq_pkg;

    // sizing
    localparam int WINDOW_SLOTS = 4;
    localparam int WAIT_DEPTH   = 16;

    localparam int SLOT_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int CNT_W   = $clog2(WINDOW_SLOTS + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int WAIT_AW = $clog2(WAIT_DEPTH);
    localparam int WAIT_CW = $clog2(WAIT_DEPTH + 1);

    // field widths
    localparam int MODE_W  = 2;
    localparam int SEQ_W   = 32;
    localparam int REF_W   = 16;
    localparam int LEN_W   = 12;
    localparam int EV_W    = 2;
    localparam int LIM_W   = 3;
    localparam int LIMC_W  = (CNT_W > LIM_W) ? CNT_W : LIM_W;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(4);

    // input modes
    localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NAK     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd3;

    // result events
    localparam logic [EV_W-1:0] EV_TX   = 2'd0;
    localparam logic [EV_W-1:0] EV_RETX = 2'd1;
    localparam logic [EV_W-1:0] EV_DROP = 2'd2;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [REF_W-1:0] fref;
        logic [LEN_W-1:0] flen;
    } t_wait_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_wait_ctl;

    // slot index base + off, modulo the window size (off never exceeds the size)
    function automatic logic [SLOT_W-1:0] idx_add(logic [SLOT_W-1:0] base,
                                                   logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(WINDOW_SLOTS)) begin
            sum = sum - SUM_W'(WINDOW_SLOTS);
        end
        return SLOT_W'(sum);
    endfunction

    // window limit clamped to 1..WINDOW_SLOTS
    function automatic logic [CNT_W-1:0] eff_limit(logic [LIM_W-1:0] lim);
        logic [LIMC_W-1:0] l;
        l = LIMC_W'(lim);
        if (l == '0) begin
            l = LIMC_W'(1);
        end
        if (l > LIMC_W'(WINDOW_SLOTS)) begin
            l = LIMC_W'(WINDOW_SLOTS);
        end
        return CNT_W'(l);
    endfunction

endpackage

[rtl/swarq_if.sv]
// swarq channel interfaces: input word, result word and window-limit write channel
// depends on swarq_pkg for field widths
interface swarq_in_if;
    import swarq_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SEQ_W-1:0]  seq_number;
    logic [REF_W-1:0]  frame_ref;
    logic [LEN_W-1:0]  frame_len;
    modport source (output valid, mode, seq_number, frame_ref, frame_len, input ready);
    modport sink   (input valid, mode, seq_number, frame_ref, frame_len, output ready);
endinterface

interface swarq_out_if;
    import swarq_pkg::*;
    logic             valid;
    logic             ready;
    logic [EV_W-1:0]  event_res;
    logic [REF_W-1:0] out_ref;
    logic [LEN_W-1:0] out_len;
    logic             last;
    modport source (output valid, event_res, out_ref, out_len, last, input ready);
    modport sink   (input valid, event_res, out_ref, out_len, last, output ready);
endinterface

interface swarq_cfg_if;
    import swarq_pkg::*;
    logic             valid;
    logic             ready;
    logic [LIM_W-1:0] window_limit;
    modport source (output valid, window_limit, input ready);
    modport sink   (input valid, window_limit, output ready);
endinterface

[rtl/sliding_window_arq_sender.sv]
// sliding_window_arq_sender: sender side of a sliding-window arq on frame descriptors
// depends on swarq_pkg, the swarq interfaces and swarq_wait_fifo
//
// One input word at a time is taken while the sequencer is idle. A word carries a mode:
// send places the frame in the window (after any waiting frames move in first), queues
// it in the wait fifo, or drops it with a drop result when the fifo is full; ack
// releases the matching frame and every older one and refills the window from the
// fifo; nak resends the matching frame; timeout resends every outstanding frame,
// oldest first. An ack, nak or timeout that matches no outstanding frame gives no
// result. Matching runs over the window one slot per cycle through a single 32-bit
// comparator, oldest first, so the oldest duplicate wins. Each result word comes from the
// same sequencer, and last marks the final result of the input word. When a send's
// moves of waiting frames fill the window, the new frame is queued in the cycle of the
// last move. A stalled result register holds the sequencer.
// The window-limit channel is always ready; the limit is clamped to 1..WINDOW_SLOTS
// and may only change while no input word is in progress.
module sliding_window_arq_sender (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swarq_in_if.sink    i_in,
    swarq_cfg_if.sink   i_cfg,
    swarq_out_if.source o_out
);
    import swarq_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_REFILL = 2'd2;
    localparam logic [1:0] S_RETX   = 2'd3;

    // sequencer and latched input word
    logic [1:0]        r_state, n_state;
    logic [MODE_W-1:0] r_mode;
    logic [SEQ_W-1:0]  r_seq;
    logic [REF_W-1:0]  r_ref;
    logic [LEN_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_i, n_i;

    // window
    logic [SLOT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SEQ_W-1:0]  r_slot_seq [WINDOW_SLOTS];
    logic [REF_W-1:0]  r_slot_ref [WINDOW_SLOTS];
    logic [LEN_W-1:0]  r_slot_len [WINDOW_SLOTS];
    logic [LIM_W-1:0]  r_window_limit;

    // result register
    logic             r_out_valid;
    logic [EV_W-1:0]  r_out_event;
    logic [REF_W-1:0] r_out_ref;
    logic [LEN_W-1:0] r_out_len;
    logic             r_out_last;

    logic             w_in_acc;
    logic             w_out_free;
    logic [CNT_W-1:0] w_eff;
    logic [SLOT_W-1:0] w_idx;
    logic             w_hit;
    logic             w_room;
    logic             w_room_next;
    logic             w_last_pos;

    logic             w_load;
    logic [EV_W-1:0]  w_ld_event;
    logic [REF_W-1:0] w_ld_ref;
    logic [LEN_W-1:0] w_ld_len;
    logic             w_ld_last;

    logic             w_slot_we;
    t_wait_entry      w_slot_data;

    t_wait_ctl          w_wctl;
    t_wait_entry        w_push_data;
    t_wait_entry        w_wait_head;
    logic [WAIT_CW-1:0] w_wait_count;

    swarq_wait_fifo u_wait (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_wctl),
        .i_push_data (w_push_data),
        .o_head_data (w_wait_head),
        .o_count     (w_wait_count)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_eff       = eff_limit(r_window_limit);

    // shared slot index: tail slot while refilling, scan position otherwise
    assign w_idx       = idx_add(r_head, (r_state == S_REFILL) ? r_count : r_i);
    // shared comparator for the window scan
    assign w_hit       = (r_slot_seq[w_idx] == r_seq);
    assign w_room      = (r_count < w_eff);
    assign w_room_next = (CNT_W'(r_count + CNT_W'(1)) < w_eff);
    assign w_last_pos  = (r_i == CNT_W'(r_count - CNT_W'(1)));

    assign w_push_data.seq  = r_seq;
    assign w_push_data.fref = r_ref;
    assign w_push_data.flen = r_len;

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_head      = r_head;
        n_count     = r_count;
        w_load      = 1'b0;
        w_ld_event  = EV_TX;
        w_ld_ref    = r_slot_ref[w_idx];
        w_ld_len    = r_slot_len[w_idx];
        w_ld_last   = 1'b0;
        w_slot_we   = 1'b0;
        w_slot_data = w_wait_head;
        w_wctl      = '0;

        unique case (r_state)
            S_IDLE: begin
                n_i = '0;
                if (w_in_acc) begin
                    if (i_in.mode == MODE_SEND) begin
                        n_state = S_REFILL;
                    end else if (r_count != '0) begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (w_hit) begin
                    if (r_mode == MODE_ACK) begin
                        // release matched frame and all older ones
                        n_head  = idx_add(r_head, CNT_W'(r_i + CNT_W'(1)));
                        n_count = CNT_W'(r_count - r_i - CNT_W'(1));
                        n_state = S_REFILL;
                    end else if (r_mode == MODE_NAK) begin
                        if (w_out_free) begin
                            w_load     = 1'b1;
                            w_ld_event = EV_RETX;
                            w_ld_last  = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end else begin
                        n_i     = '0;
                        n_state = S_RETX;
                    end
                end else if (w_last_pos) begin
                    n_state = S_IDLE;
                end else begin
                    n_i = CNT_W'(r_i + CNT_W'(1));
                end
            end
            S_REFILL: begin
                if (w_room && (w_wait_count != '0)) begin
                    // move one waiting frame into the window
                    if (w_out_free) begin
                        w_wctl.pop = 1'b1;
                        w_slot_we  = 1'b1;
                        n_count    = CNT_W'(r_count + CNT_W'(1));
                        w_load     = 1'b1;
                        w_ld_event = EV_TX;
                        w_ld_ref   = w_wait_head.fref;
                        w_ld_len   = w_wait_head.flen;
                        if (r_mode == MODE_SEND) begin
                            // the new frame follows only if a slot is still free
                            w_ld_last = !w_room_next;
                        end else begin
                            w_ld_last = !(w_room_next && (w_wait_count != WAIT_CW'(1)));
                        end
                        if (w_ld_last) begin
                            if (r_mode == MODE_SEND) begin
                                // window now full: the new frame joins the queue
                                w_wctl.push = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                end else if (r_mode != MODE_SEND) begin
                    n_state = S_IDLE;
                end else if (w_room) begin
                    // fifo empty and a slot free: transmit the new frame
                    if (w_out_free) begin
                        w_slot_we   = 1'b1;
                        w_slot_data = w_push_data;
                        n_count     = CNT_W'(r_count + CNT_W'(1));
                        w_load      = 1'b1;
                        w_ld_event  = EV_TX;
                        w_ld_ref    = r_ref;
                        w_ld_len    = r_len;
                        w_ld_last   = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (w_wait_count < WAIT_CW'(WAIT_DEPTH)) begin
                    w_wctl.push = 1'b1;
                    n_state     = S_IDLE;
                end else if (w_out_free) begin
                    w_load     = 1'b1;
                    w_ld_event = EV_DROP;
                    w_ld_ref   = r_ref;
                    w_ld_len   = r_len;
                    w_ld_last  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_RETX: begin
                // resend every outstanding frame, oldest first
                if (w_out_free) begin
                    w_load     = 1'b1;
                    w_ld_event = EV_RETX;
                    w_ld_last  = w_last_pos;
                    n_i        = CNT_W'(r_i + CNT_W'(1));
                    if (w_last_pos) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_i            <= '0;
            r_head         <= '0;
            r_count        <= '0;
            r_window_limit <= LIMIT_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cfg.valid && i_cfg.ready) begin
                r_window_limit <= i_cfg.window_limit;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: latched word, window slots, result word
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode <= i_in.mode;
            r_seq  <= i_in.seq_number;
            r_ref  <= i_in.frame_ref;
            r_len  <= i_in.frame_len;
        end
        if (w_slot_we) begin
            r_slot_seq[w_idx] <= w_slot_data.seq;
            r_slot_ref[w_idx] <= w_slot_data.fref;
            r_slot_len[w_idx] <= w_slot_data.flen;
        end
        if (w_load) begin
            r_out_event <= w_ld_event;
            r_out_ref   <= w_ld_ref;
            r_out_len   <= w_ld_len;
            r_out_last  <= w_ld_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.event_res = r_out_event;
    assign o_out.out_ref   = r_out_ref;
    assign o_out.out_len   = r_out_len;
    assign o_out.last      = r_out_last;

    // window never holds more frames than it has slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW_SLOTS))
        else $error("window count above slot count");

    // a frame is only taken from the wait fifo when one is there
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wctl.pop |-> (w_wait_count != '0))
        else $error("pop from empty wait fifo");

    // the result marked last ends the word's processing
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_ld_last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after last result");

endmodule

[rtl/swarq_wait_fifo.sv]
// swarq_wait_fifo: bounded fifo of frame descriptors waiting for a window slot
// depends on swarq_pkg (entry type, control struct, depth)
module swarq_wait_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  swarq_pkg::t_wait_ctl   i_ctl,
    input  swarq_pkg::t_wait_entry i_push_data,
    output swarq_pkg::t_wait_entry o_head_data,
    output logic [swarq_pkg::WAIT_CW-1:0] o_count
);
    import swarq_pkg::*;

    t_wait_entry        r_mem [WAIT_DEPTH];
    t_wait_entry        r_head_data;
    logic [WAIT_AW-1:0] r_head;
    logic [WAIT_AW-1:0] r_tail;
    logic [WAIT_CW-1:0] r_count;
    logic [WAIT_AW-1:0] w_head_n;

    function automatic logic [WAIT_AW-1:0] ptr_next(logic [WAIT_AW-1:0] p);
        return (p == WAIT_AW'(WAIT_DEPTH - 1)) ? '0 : WAIT_AW'(p + WAIT_AW'(1));
    endfunction

    assign w_head_n = i_ctl.pop ? ptr_next(r_head) : r_head;

    // head word is read into a register, taken straight from the push when
    // the pushed word becomes the new head
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_push_data;
        end
        if (i_ctl.push && (r_tail == w_head_n)) begin
            r_head_data <= i_push_data;
        end else begin
            r_head_data <= r_mem[w_head_n];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.push) begin
                r_tail <= ptr_next(r_tail);
            end
            if (i_ctl.pop) begin
                r_head <= w_head_n;
            end
            if (i_ctl.push && !i_ctl.pop) begin
                r_count <= WAIT_CW'(r_count + WAIT_CW'(1));
            end else if (i_ctl.pop && !i_ctl.push) begin
                r_count <= WAIT_CW'(r_count - WAIT_CW'(1));
            end
        end
    end

    assign o_head_data = r_head_data;
    assign o_count     = r_count;

endmodule
